@@ sv/rtcprp_pkg.sv @@
package rtcprp_pkg;

    localparam int unsigned POS_W = 20;
    localparam int unsigned IDX_W = 5;
    localparam int unsigned DECL_W = 19;
    localparam int unsigned STAGE_DEPTH = 5;
    localparam int unsigned STAGE_AW = 3;
    localparam int unsigned TDATA_W = 232;

    localparam logic [POS_W-1:0] POS_MAX = 20'hFFFFF;
    localparam logic [POS_W-1:0] MIN_LEN_SR = 20'd28;
    localparam logic [POS_W-1:0] MIN_LEN_RR = 20'd8;
    localparam logic [POS_W-1:0] POS_LENGTH_LO = 20'd3;
    localparam logic [POS_W-1:0] POS_HEADER_END = 20'd7;
    localparam logic [POS_W-1:0] POS_BLOCKS = 20'd8;
    localparam logic [POS_W-1:0] POS_INFO_END = 20'd27;
    localparam logic [IDX_W-1:0] IDX_BLOCK_END = 5'd23;

    localparam logic [1:0] RTCP_VERSION = 2'd2;
    localparam logic [7:0] PT_SR = 8'd200;
    localparam logic [7:0] PT_RR = 8'd201;
    localparam logic [23:0] LOST_MASK = 24'hFFFFFF;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_SENDER_INFO = 2'd1,
        KIND_REPORT_BLOCK = 2'd2,
        KIND_STATUS = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_WRONG_TYPE = 3'd3,
        ST_UNDER_LENGTH = 3'd4
    } status_t;

    typedef struct packed {
        kind_t       kind;
        status_t     status;
        logic        last_record;
        logic [31:0] source_id;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [31:0] word_d;
        logic [31:0] word_e;
        logic [7:0]  fraction_lost;
        logic [23:0] lost_count;
    } record_t;

    typedef struct packed {
        logic push_data;
        logic push_status;
    } push_t;

    localparam record_t RECORD_ZERO = '{
        kind: KIND_HEADER, status: ST_OK, last_record: 1'b0,
        source_id: 32'd0, word_a: 32'd0, word_b: 32'd0, word_c: 32'd0,
        word_d: 32'd0, word_e: 32'd0, fraction_lost: 8'd0, lost_count: 24'd0
    };

endpackage

@@ sv/rtcp_report_parser_unit.sv @@
// RTCP sender and receiver report parser.
// Packet bytes arrive in network order on the s_ stream, one byte per request,
// with s_tlast on the final byte of the packet. Parsed records leave on the
// m_ stream: m_tuser carries the record kind and m_tlast marks the final
// status record of each packet.
// The expected packet type is set through cfg_wr_en and cfg_wr_data while the
// block is idle: 0 selects sender reports, 1 selects receiver reports.
// Each accepted byte is parsed in the cycle it is taken; any record it
// completes is stored in the output queue at the end of that cycle.
// A byte can be accepted in every cycle while the queue has room.
// Records wait in a four-entry output queue. The block takes a byte only while
// the queue has room for two records, since the last byte of a packet can
// complete a report block and the status record together. When the receiver
// stalls, the queue fills and s_tready falls until records are taken.
// Reset clears the parser, the queue and the type selection, which returns to
// sender reports.
module rtcp_report_parser_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // data_byte [7:0]
    input  logic [7:0]                     s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status [2:0], source_id [34:3], word_a [66:35], word_b [98:67],
    // word_c [130:99], word_d [162:131], word_e [194:163],
    // fraction_lost [202:195], lost_count [226:203], zero [231:227]
    output logic [rtcprp_pkg::TDATA_W-1:0] m_tdata,
    // record_kind [1:0]
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);

    logic                s_accept;
    rtcprp_pkg::push_t   push;
    rtcprp_pkg::record_t rec_data;
    rtcprp_pkg::record_t rec_status;
    rtcprp_pkg::record_t out_rec;
    logic                room;

    assign s_tready = room;
    assign s_accept = s_tvalid && room;

    rtcprp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_accept),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .push        (push),
        .rec_data    (rec_data),
        .rec_status  (rec_status)
    );

    rtcprp_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .rec_data   (rec_data),
        .rec_status (rec_status),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_rec    (out_rec)
    );

    assign m_tuser = out_rec.kind;
    assign m_tlast = out_rec.last_record;
    assign m_tdata = {5'd0, out_rec.lost_count, out_rec.fraction_lost, out_rec.word_e,
                      out_rec.word_d, out_rec.word_c, out_rec.word_b, out_rec.word_a,
                      out_rec.source_id, out_rec.status};

endmodule

@@ sv/rtcprp_parser.sv @@
module rtcprp_parser (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_wr_data,
    input  logic                     in_valid,
    input  logic [7:0]               in_byte,
    input  logic                     in_last,
    output rtcprp_pkg::push_t        push,
    output rtcprp_pkg::record_t      rec_data,
    output rtcprp_pkg::record_t      rec_status
);

    logic                            rr_reg;
    logic [rtcprp_pkg::POS_W-1:0]    pos_reg, pos_next, pos_inc;
    logic [rtcprp_pkg::IDX_W-1:0]    idx_reg, idx_next, idx_upd;
    logic [31:0]                     shift_reg, shift_next;
    logic [5:0]                      hdr_reg, hdr_next, hdr_upd;
    logic [rtcprp_pkg::DECL_W-1:0]   decl_reg, decl_next, decl_upd;
    rtcprp_pkg::status_t             err_reg, err_next, err_upd;
    logic [31:0]                     staged_reg [rtcprp_pkg::STAGE_DEPTH];
    logic [31:0]                     staged_rd [rtcprp_pkg::STAGE_DEPTH];
    logic                            st_we;
    logic [rtcprp_pkg::STAGE_AW-1:0] st_addr;
    logic [16:0]                     len_p1;
    logic                            info;
    logic                            emit;
    logic [rtcprp_pkg::POS_W-1:0]    min_len;
    rtcprp_pkg::status_t             final_status;

    assign shift_next = {shift_reg[23:0], in_byte};
    assign pos_inc = (pos_reg == rtcprp_pkg::POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign len_p1 = {1'b0, shift_next[15:0]} + 17'd1;
    assign info = !rr_reg && (pos_reg < rtcprp_pkg::MIN_LEN_SR);
    assign st_we = (pos_reg >= rtcprp_pkg::POS_BLOCKS) && (idx_reg[1:0] == 2'b11)
                   && (idx_reg[4:2] < 3'(rtcprp_pkg::STAGE_DEPTH));
    assign st_addr = idx_reg[4:2];
    assign min_len = rr_reg ? rtcprp_pkg::MIN_LEN_RR : rtcprp_pkg::MIN_LEN_SR;

    always_comb begin
        for (int k = 0; k < rtcprp_pkg::STAGE_DEPTH; k++) begin
            staged_rd[k] = (st_we && (st_addr == 3'(k))) ? shift_next : staged_reg[k];
        end
    end

    always_comb begin
        idx_upd = idx_reg;
        hdr_upd = hdr_reg;
        decl_upd = decl_reg;
        err_upd = err_reg;
        emit = 1'b0;
        rec_data = rtcprp_pkg::RECORD_ZERO;
        if (pos_reg == '0) begin
            hdr_upd = in_byte[5:0];
            if (in_byte[7:6] != rtcprp_pkg::RTCP_VERSION) begin
                err_upd = rtcprp_pkg::ST_BAD_VERSION;
            end
        end else if (pos_reg == 20'd1) begin
            if (err_reg == rtcprp_pkg::ST_OK
                && in_byte != (rr_reg ? rtcprp_pkg::PT_RR : rtcprp_pkg::PT_SR)) begin
                err_upd = rtcprp_pkg::ST_WRONG_TYPE;
            end
        end else if (pos_reg == rtcprp_pkg::POS_LENGTH_LO) begin
            decl_upd = {len_p1, 2'b00};
        end else if (pos_reg == rtcprp_pkg::POS_HEADER_END) begin
            idx_upd = '0;
            emit = (err_reg == rtcprp_pkg::ST_OK);
            rec_data.kind = rtcprp_pkg::KIND_HEADER;
            rec_data.source_id = shift_next;
            rec_data.word_a = {13'd0, decl_reg};
            rec_data.word_b = {27'd0, hdr_reg[4:0]};
            rec_data.word_c = {31'd0, hdr_reg[5]};
        end else if (pos_reg >= rtcprp_pkg::POS_BLOCKS) begin
            if (info && pos_reg == rtcprp_pkg::POS_INFO_END) begin
                idx_upd = '0;
                emit = (err_reg == rtcprp_pkg::ST_OK);
                rec_data.kind = rtcprp_pkg::KIND_SENDER_INFO;
                rec_data.word_a = staged_rd[0];
                rec_data.word_b = staged_rd[1];
                rec_data.word_c = staged_rd[2];
                rec_data.word_d = staged_rd[3];
                rec_data.word_e = staged_rd[4];
            end else if (!info && idx_reg >= rtcprp_pkg::IDX_BLOCK_END) begin
                idx_upd = '0;
                emit = (err_reg == rtcprp_pkg::ST_OK);
                rec_data.kind = rtcprp_pkg::KIND_REPORT_BLOCK;
                rec_data.source_id = staged_rd[0];
                rec_data.word_a = staged_rd[2];
                rec_data.word_b = staged_rd[3];
                rec_data.word_c = staged_rd[4];
                rec_data.word_d = shift_next;
                rec_data.fraction_lost = staged_rd[1][31:24];
                rec_data.lost_count = staged_rd[1][23:0] & rtcprp_pkg::LOST_MASK;
            end else begin
                idx_upd = idx_reg + 1'b1;
            end
        end
    end

    always_comb begin
        if (pos_inc < min_len) begin
            final_status = rtcprp_pkg::ST_TOO_SHORT;
        end else if (err_upd == rtcprp_pkg::ST_BAD_VERSION) begin
            final_status = rtcprp_pkg::ST_BAD_VERSION;
        end else if (err_upd == rtcprp_pkg::ST_WRONG_TYPE) begin
            final_status = rtcprp_pkg::ST_WRONG_TYPE;
        end else if (pos_inc < {1'b0, decl_upd}) begin
            final_status = rtcprp_pkg::ST_UNDER_LENGTH;
        end else begin
            final_status = rtcprp_pkg::ST_OK;
        end
        rec_status = rtcprp_pkg::RECORD_ZERO;
        rec_status.kind = rtcprp_pkg::KIND_STATUS;
        rec_status.status = final_status;
        rec_status.last_record = 1'b1;
    end

    always_comb begin
        push.push_data = in_valid && emit;
        push.push_status = in_valid && in_last;
        if (in_last) begin
            pos_next = '0;
            idx_next = '0;
            hdr_next = '0;
            decl_next = '0;
            err_next = rtcprp_pkg::ST_OK;
        end else begin
            pos_next = pos_inc;
            idx_next = idx_upd;
            hdr_next = hdr_upd;
            decl_next = decl_upd;
            err_next = err_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rr_reg <= 1'b0;
            pos_reg <= '0;
            idx_reg <= '0;
            shift_reg <= '0;
            hdr_reg <= '0;
            decl_reg <= '0;
            err_reg <= rtcprp_pkg::ST_OK;
        end else begin
            if (cfg_wr_en) begin
                rr_reg <= cfg_wr_data;
            end
            if (in_valid) begin
                pos_reg <= pos_next;
                idx_reg <= idx_next;
                shift_reg <= in_last ? 32'd0 : shift_next;
                hdr_reg <= hdr_next;
                decl_reg <= decl_next;
                err_reg <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && st_we) begin
            staged_reg[st_addr] <= shift_next;
        end
    end

endmodule

@@ sv/rtcprp_out_queue.sv @@
module rtcprp_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  rtcprp_pkg::push_t   push,
    input  rtcprp_pkg::record_t rec_data,
    input  rtcprp_pkg::record_t rec_status,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output rtcprp_pkg::record_t out_rec
);

    rtcprp_pkg::record_t mem_reg [4];
    logic [1:0]          wr_ptr_reg, wr_ptr_next;
    logic [1:0]          rd_ptr_reg, rd_ptr_next;
    logic [2:0]          count_reg, count_next;
    logic                pop;
    logic [2:0]          n_push;

    assign out_valid = (count_reg != 3'd0);
    assign out_rec = mem_reg[rd_ptr_reg];
    assign room = (count_reg <= 3'd2);
    assign pop = out_valid && out_ready;
    assign n_push = {2'd0, push.push_data} + {2'd0, push.push_status};
    assign wr_ptr_next = wr_ptr_reg + n_push[1:0];
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next = count_reg + n_push - {2'd0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.push_data) begin
            mem_reg[wr_ptr_reg] <= rec_data;
            if (push.push_status) begin
                mem_reg[wr_ptr_reg + 2'd1] <= rec_status;
            end
        end else if (push.push_status) begin
            mem_reg[wr_ptr_reg] <= rec_status;
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_BYTES = 80;
    localparam int PRINT_LIMIT = 30;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_data = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [rtcprp_pkg::TDATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;

    rtcp_report_parser_unit dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    // Parser state as seen from outside, kept alongside the block.
    logic                              expect_rr = 1'b0;
    logic [rtcprp_pkg::POS_W-1:0]      byte_pos;
    logic [rtcprp_pkg::IDX_W-1:0]      section_idx;
    logic [31:0]                       last_four;
    logic [31:0]                       section_words [rtcprp_pkg::STAGE_DEPTH];
    logic [15:0]                       first_two;
    logic [rtcprp_pkg::DECL_W-1:0]     declared_len;
    rtcprp_pkg::status_t               latched_error;

    rtcprp_pkg::record_t expected_records[$];
    logic [7:0] pkt_buf[$];

    int fail_count = 0;
    int cycle_count = 0;
    int record_count = 0;
    int packet_count = 0;
    int byte_count = 0;
    int status_seen [5] = '{0, 0, 0, 0, 0};
    bit tx_gaps = 1'b1;
    int tx_burst = 0;
    bit rx_stall_en = 1'b1;
    int rx_left = 0;

    task automatic store_expected(input rtcprp_pkg::record_t rec);
        expected_records = {expected_records, rec};
    endtask

    task automatic append_byte(input logic [7:0] value);
        pkt_buf = {pkt_buf, value};
    endtask

    task automatic clear_packet_state();
        byte_pos = '0;
        section_idx = '0;
        last_four = '0;
        for (int i = 0; i < rtcprp_pkg::STAGE_DEPTH; i++) section_words[i] = '0;
        first_two = '0;
        declared_len = '0;
        latched_error = rtcprp_pkg::ST_OK;
    endtask

    task automatic parse_report_byte(input logic [7:0] value, input logic is_last);
        rtcprp_pkg::record_t rec;
        logic [rtcprp_pkg::POS_W-1:0] p;
        logic [rtcprp_pkg::IDX_W-1:0] idx;
        logic [31:0] len_calc;
        logic info;
        p = byte_pos;
        last_four = {last_four[23:0], value};
        if (p == '0) begin
            first_two = {value, 8'h00};
            if (value[7:6] != rtcprp_pkg::RTCP_VERSION)
                latched_error = rtcprp_pkg::ST_BAD_VERSION;
        end else if (p == 20'd1) begin
            first_two[7:0] = value;
            if (latched_error == rtcprp_pkg::ST_OK
                && value != (expect_rr ? rtcprp_pkg::PT_RR : rtcprp_pkg::PT_SR))
                latched_error = rtcprp_pkg::ST_WRONG_TYPE;
        end else if (p == rtcprp_pkg::POS_LENGTH_LO) begin
            len_calc = ({16'd0, last_four[15:0]} + 32'd1) * 32'd4;
            declared_len = len_calc[rtcprp_pkg::DECL_W-1:0];
        end else if (p == rtcprp_pkg::POS_HEADER_END) begin
            section_idx = '0;
            if (latched_error == rtcprp_pkg::ST_OK) begin
                rec = rtcprp_pkg::RECORD_ZERO;
                rec.kind = rtcprp_pkg::KIND_HEADER;
                rec.source_id = last_four;
                rec.word_a = {13'd0, declared_len};
                rec.word_b = {27'd0, first_two[12:8]};
                rec.word_c = {31'd0, first_two[13]};
                store_expected(rec);
            end
        end else if (p >= rtcprp_pkg::POS_BLOCKS) begin
            idx = section_idx;
            info = !expect_rr && (p < rtcprp_pkg::MIN_LEN_SR);
            if (idx[1:0] == 2'd3 && idx[4:2] < rtcprp_pkg::STAGE_DEPTH)
                section_words[idx[4:2]] = last_four;
            if (info && p == rtcprp_pkg::POS_INFO_END) begin
                if (latched_error == rtcprp_pkg::ST_OK) begin
                    rec = rtcprp_pkg::RECORD_ZERO;
                    rec.kind = rtcprp_pkg::KIND_SENDER_INFO;
                    rec.word_a = section_words[0];
                    rec.word_b = section_words[1];
                    rec.word_c = section_words[2];
                    rec.word_d = section_words[3];
                    rec.word_e = section_words[4];
                    store_expected(rec);
                end
                section_idx = '0;
            end else if (!info && idx >= rtcprp_pkg::IDX_BLOCK_END) begin
                if (latched_error == rtcprp_pkg::ST_OK) begin
                    rec = rtcprp_pkg::RECORD_ZERO;
                    rec.kind = rtcprp_pkg::KIND_REPORT_BLOCK;
                    rec.source_id = section_words[0];
                    rec.word_a = section_words[2];
                    rec.word_b = section_words[3];
                    rec.word_c = section_words[4];
                    rec.word_d = last_four;
                    rec.fraction_lost = section_words[1][31:24];
                    rec.lost_count = section_words[1][23:0];
                    store_expected(rec);
                end
                section_idx = '0;
            end else begin
                section_idx = idx + 5'd1;
            end
        end
        if (byte_pos != rtcprp_pkg::POS_MAX) byte_pos = byte_pos + 20'd1;
        if (is_last) begin
            rec = rtcprp_pkg::RECORD_ZERO;
            rec.kind = rtcprp_pkg::KIND_STATUS;
            rec.last_record = 1'b1;
            if (byte_pos < (expect_rr ? rtcprp_pkg::MIN_LEN_RR : rtcprp_pkg::MIN_LEN_SR))
                rec.status = rtcprp_pkg::ST_TOO_SHORT;
            else if (latched_error != rtcprp_pkg::ST_OK)
                rec.status = latched_error;
            else if (byte_pos < {1'b0, declared_len})
                rec.status = rtcprp_pkg::ST_UNDER_LENGTH;
            else
                rec.status = rtcprp_pkg::ST_OK;
            store_expected(rec);
            clear_packet_state();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("%0t: record %0d: %s is %h, expected %h", $realtime, record_count,
                     what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge aclk) begin : check_records
        rtcprp_pkg::record_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_records.size() == 0) begin
                report_mismatch("unexpected record of kind", {30'd0, m_tuser}, 32'd0);
            end else begin
                want = expected_records.pop_front();
                check_field("record kind", {30'd0, m_tuser}, {30'd0, want.kind});
                check_field("status", {29'd0, m_tdata[2:0]}, {29'd0, want.status});
                check_field("last record", {31'd0, m_tlast}, {31'd0, want.last_record});
                check_field("source id", m_tdata[34:3], want.source_id);
                check_field("word a", m_tdata[66:35], want.word_a);
                check_field("word b", m_tdata[98:67], want.word_b);
                check_field("word c", m_tdata[130:99], want.word_c);
                check_field("word d", m_tdata[162:131], want.word_d);
                check_field("word e", m_tdata[194:163], want.word_e);
                check_field("fraction lost", {24'd0, m_tdata[202:195]},
                            {24'd0, want.fraction_lost});
                check_field("lost count", {8'd0, m_tdata[226:203]}, {8'd0, want.lost_count});
                check_field("padding", {27'd0, m_tdata[231:227]}, 32'd0);
                if (want.kind == rtcprp_pkg::KIND_STATUS) status_seen[want.status]++;
            end
            record_count++;
        end
    end

    always @(posedge aclk) begin : drive_result_ready
        int r;
        r = $urandom_range(0, 99);
        if (!rx_stall_en) begin
            m_tready <= 1'b1;
            rx_left <= 0;
        end else if (rx_left > 0) begin
            rx_left <= rx_left - 1;
        end else if (m_tready) begin
            m_tready <= 1'b0;
            if (r < 80) rx_left <= $urandom_range(0, 2);
            else if (r < 96) rx_left <= $urandom_range(3, 11);
            else rx_left <= $urandom_range(30, 80);
        end else begin
            m_tready <= 1'b1;
            if (r < 85) rx_left <= $urandom_range(0, 11);
            else rx_left <= $urandom_range(50, 150);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int gap;
        int r;
        gap = 0;
        if (tx_gaps) begin
            r = $urandom_range(0, 99);
            if (tx_burst > 0) tx_burst--;
            else if (r < 3) tx_burst = $urandom_range(20, 60);
            else if (r < 55) gap = 0;
            else if (r < 90) gap = $urandom_range(1, 3);
            else if (r < 98) gap = $urandom_range(4, 10);
            else gap = $urandom_range(20, 40);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tlast <= is_last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        parse_report_byte(value, is_last);
        byte_count++;
    endtask

    task automatic send_packet(input int first);
        for (int i = first; i < pkt_buf.size(); i++)
            send_byte(pkt_buf[i], i == pkt_buf.size() - 1);
        packet_count++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_records.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_report_type(input logic rr);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= rr;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        expect_rr = rr;
    endtask

    // fill 0 gives all-zero fields, 1 all-ones fields with padding and maximum
    // count, anything else random content.
    task automatic build_report(input logic [1:0] ver, input logic [7:0] ptype,
                                input bit with_info, input int blocks, input int fill);
        int size;
        logic [15:0] len_words;
        size = 8 + (with_info ? 20 : 0) + 24 * blocks;
        len_words = 16'(size / 4 - 1);
        pkt_buf.delete();
        case (fill)
            0: append_byte({ver, 6'h00});
            1: append_byte({ver, 6'h3f});
            default: append_byte({ver, 6'($urandom)});
        endcase
        append_byte(ptype);
        append_byte(len_words[15:8]);
        append_byte(len_words[7:0]);
        for (int i = 4; i < size; i++) begin
            case (fill)
                0: append_byte(8'h00);
                1: append_byte(8'hff);
                default: append_byte(8'($urandom));
            endcase
        end
    endtask

    task automatic test_sender_reports();
        build_report(rtcprp_pkg::RTCP_VERSION, rtcprp_pkg::PT_SR, 1, 0, 0);
        send_packet(0);
        build_report(rtcprp_pkg::RTCP_VERSION, rtcprp_pkg::PT_SR, 1, 1, 1);
        send_packet(0);
        build_report(rtcprp_pkg::RTCP_VERSION, rtcprp_pkg::PT_SR, 1, 2, 2);
        repeat (3) append_byte(8'($urandom));
        send_packet(0);
    endtask

    task automatic test_receiver_reports();
        set_report_type(1'b1);
        build_report(rtcprp_pkg::RTCP_VERSION, rtcprp_pkg::PT_RR, 0, 0, 2);
        send_packet(0);
        build_report(rtcprp_pkg::RTCP_VERSION, rtcprp_pkg::PT_RR, 0, 2, 2);
        send_packet(0);
        build_report(rtcprp_pkg::RTCP_VERSION, rtcprp_pkg::PT_RR, 0, 1, 1);
        send_packet(0);
    endtask

    task automatic test_error_status();
        build_report(rtcprp_pkg::RTCP_VERSION, rtcprp_pkg::PT_RR, 0, 0, 2);
        void'(pkt_buf.pop_back());
        send_packet(0);
        build_report(2'd1, rtcprp_pkg::PT_SR, 0, 1, 2);
        send_packet(0);
        build_report(rtcprp_pkg::RTCP_VERSION, rtcprp_pkg::PT_SR, 0, 1, 2);
        send_packet(0);
        build_report(rtcprp_pkg::RTCP_VERSION, rtcprp_pkg::PT_RR, 0, 2, 2);
        repeat (10) void'(pkt_buf.pop_back());
        send_packet(0);
        set_report_type(1'b0);
        build_report(rtcprp_pkg::RTCP_VERSION, rtcprp_pkg::PT_SR, 1, 1, 2);
        while (pkt_buf.size() > 20) void'(pkt_buf.pop_back());
        send_packet(0);
        build_report(2'd3, rtcprp_pkg::PT_SR, 1, 1, 2);
        send_packet(0);
        build_report(2'd0, rtcprp_pkg::PT_SR, 1, 0, 0);
        send_packet(0);
        build_report(rtcprp_pkg::RTCP_VERSION, rtcprp_pkg::PT_RR, 1, 0, 2);
        send_packet(0);
        pkt_buf.delete();
        append_byte(8'($urandom));
        send_packet(0);
        build_report(rtcprp_pkg::RTCP_VERSION, rtcprp_pkg::PT_SR, 1, 1, 2);
        pkt_buf[2] = 8'hff;
        pkt_buf[3] = 8'hff;
        send_packet(0);
    endtask

    // The type check on the second byte uses the setting in force at that byte.
    task automatic test_type_switch_mid_packet();
        build_report(rtcprp_pkg::RTCP_VERSION, rtcprp_pkg::PT_RR, 0, 1, 2);
        send_byte(pkt_buf[0], 1'b0);
        set_report_type(1'b1);
        send_packet(1);
    endtask

    task automatic test_random_packets();
        int start;
        int r;
        int blocks;
        int size;
        start = byte_count;
        while (byte_count - start < RANDOM_BYTES) begin
            if ($urandom_range(0, 7) == 0) set_report_type(1'($urandom));
            else if ($urandom_range(0, 9) == 0) wait_idle();
            r = $urandom_range(0, 9);
            blocks = (r < 3) ? 0 : (r < 7) ? 1 : (r < 9) ? 2 : 3;
            build_report(rtcprp_pkg::RTCP_VERSION,
                         expect_rr ? rtcprp_pkg::PT_RR : rtcprp_pkg::PT_SR,
                         !expect_rr, blocks, 2);
            size = pkt_buf.size();
            r = $urandom_range(0, 99);
            if (r < 70) begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 5)) append_byte(8'($urandom));
            end else begin
                case ($urandom_range(0, 4))
                    0: pkt_buf[0][7:6] = ($urandom_range(0, 2) == 2) ? 2'd3
                                         : 2'($urandom_range(0, 1));
                    1: pkt_buf[1] = 8'($urandom);
                    2: repeat ($urandom_range(1, size - 1)) void'(pkt_buf.pop_back());
                    3: begin
                        pkt_buf[2] = 8'($urandom);
                        pkt_buf[3] = 8'($urandom);
                    end
                    default: begin
                        pkt_buf.delete();
                        repeat ($urandom_range(1, 60)) append_byte(8'($urandom));
                    end
                endcase
            end
            send_packet(0);
        end
    endtask

    initial begin
        int waited;
        clear_packet_state();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_sender_reports();
        test_receiver_reports();
        test_error_status();
        test_type_switch_mid_packet();
        test_random_packets();
        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_records.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);
        if (expected_records.size() != 0)
            report_mismatch("records never produced", 32'(expected_records.size()), 32'd0);
        $display("Sent %0d packets, %0d bytes, under both report types; %0d records checked.",
                 packet_count, byte_count, record_count);
        $display("Status records: ok %0d, too short %0d, bad version %0d,",
                 status_seen[0], status_seen[1], status_seen[2]);
        $display("wrong type %0d, short of length %0d.", status_seen[3], status_seen[4]);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
